// ----- rtl/core/pbrk_pkg.sv -----
// Shared types and constants for the paced byte ring with keepalive.
package pbrk_pkg;

    localparam int unsigned MIN_GAP_W = 20;
    localparam int unsigned KA_TIMEOUT_W = 27;
    localparam int unsigned CFG_DATA_W = 27;
    localparam int unsigned DROP_W = 32;
    localparam int unsigned TIME_W = 64;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PACE = 2'd1;
    localparam logic [1:0] OP_SEEN = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] CFG_MIN_GAP = 2'd0;
    localparam logic [1:0] CFG_KA_ENABLE = 2'd1;
    localparam logic [1:0] CFG_KA_TIMEOUT = 2'd2;

    localparam logic [MIN_GAP_W-1:0] MIN_GAP_RST = 20'd520;
    localparam logic [KA_TIMEOUT_W-1:0] KA_TIMEOUT_RST = 27'd100000;

    localparam logic [7:0] START_MARK = 8'h87;
    localparam logic [7:0] KEEPALIVE_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              is_keepalive;
        logic              last_of_run;
        logic [DROP_W-1:0] drops_so_far;
    } pbrk_result_t;

endpackage

// ----- rtl/core/pbrk_out_stage.sv -----
// Output holding register between the pacing sequencer and the result channel.
module pbrk_out_stage
    import pbrk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pbrk_result_t item,
    output logic         can_take,
    output logic         out_valid,
    input  logic         out_stall,
    output pbrk_result_t out_item
);

    logic         valid_reg;
    pbrk_result_t item_reg;

    assign can_take = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_take)
        begin
            item_reg <= item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/core/paced_byte_ring_with_keepalive_core.sv -----
// Top level: overwrite-oldest byte ring with paced drain and keepalive byte.
//
// Channel  Direction  Handshake              Payload
// in       in         in_valid / in_stall    operation, data_byte, now_time
// out      out        out_valid / out_stall  out_byte, is_keepalive, last_of_run, drops_so_far
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Push, serial-seen and restart leave in_stall low, so the input stays open for the next transaction.
// Pace drains each byte through S_DECIDE (ring read) and then S_FETCH (hand-off to the pending
// byte register), and ends with a last decision in S_DECIDE and the final transaction in S_FLUSH;
// stalls on out can hold S_DECIDE, S_FETCH and S_FLUSH. The registered ring read is why each byte needs both steps.
// Reset is immediate; the ring needs no clearing pass.
module paced_byte_ring_with_keepalive_core
    import pbrk_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024,
    parameter int unsigned MAX_BURST  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [7:0]            data_byte,
    input  logic [TIME_W-1:0]     now_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  is_keepalive,
    output logic                  last_of_run,
    output logic [DROP_W-1:0]     drops_so_far,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(RING_DEPTH + 1);
    localparam int unsigned CW = $clog2(MAX_BURST + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_FLUSH  = 3'd3;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] rd_data_reg;

    logic [2:0]              state_reg, state_next;
    logic [PW-1:0]           write_pos_reg, write_pos_next;
    logic [PW-1:0]           read_pos_reg, read_pos_next;
    logic [FW-1:0]           fill_reg, fill_next;
    logic [DROP_W-1:0]       drop_reg, drop_next;
    logic [TIME_W-1:0]       nst_reg, nst_next;
    logic                    started_reg, started_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [7:0]              pend_byte_reg;
    logic                    pend_ka_reg;
    logic [TIME_W-1:0]       now_reg;

    logic [MIN_GAP_W-1:0]    min_gap_reg;
    logic                    ka_en_reg;
    logic [KA_TIMEOUT_W-1:0] ka_timeout_reg;

    logic                    in_take;
    logic                    mem_we;
    logic                    mem_re;
    logic                    pend_load;
    logic                    pend_ka_load;
    logic                    out_push;
    logic                    push_last;
    logic                    out_ready;
    logic [TIME_W-1:0]       diff;
    logic                    byte_ok;
    logic                    ka_ok;
    pbrk_result_t            res_in;
    pbrk_result_t            res_out;

    function automatic logic [PW-1:0] adv_pos(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        begin
            if (p == PW'(RING_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && (state_reg == S_IDLE);

    assign diff    = now_reg - nst_reg;
    assign byte_ok = (fill_reg != '0) && (cnt_reg < CW'(MAX_BURST))
                     && (diff >= TIME_W'(min_gap_reg));
    assign ka_ok   = ka_en_reg && started_reg && (fill_reg == '0)
                     && (diff >= TIME_W'(ka_timeout_reg));

    always_comb
    begin
        state_next      = state_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        nst_next        = nst_reg;
        started_next    = started_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        pend_load       = 1'b0;
        pend_ka_load    = 1'b0;
        out_push        = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (operation)
                        OP_PUSH:
                        begin
                            if (data_byte == START_MARK)
                            begin
                                started_next = 1'b1;
                            end
                            mem_we = 1'b1;
                            if (fill_reg == FW'(RING_DEPTH))
                            begin
                                read_pos_next = adv_pos(read_pos_reg);
                                drop_next     = drop_reg + 1'b1;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            write_pos_next = adv_pos(write_pos_reg);
                        end
                        OP_SEEN:
                        begin
                            if (data_byte == START_MARK)
                            begin
                                started_next = 1'b1;
                            end
                        end
                        OP_RESTART:
                        begin
                            write_pos_next = '0;
                            read_pos_next  = '0;
                            fill_next      = '0;
                            drop_next      = '0;
                            started_next   = 1'b0;
                            nst_next       = now_time;
                        end
                        OP_PACE:
                        begin
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_DECIDE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                if (byte_ok)
                begin
                    mem_re        = 1'b1;
                    read_pos_next = adv_pos(read_pos_reg);
                    fill_next     = fill_reg - 1'b1;
                    nst_next      = nst_reg + TIME_W'(min_gap_reg);
                    cnt_next      = cnt_reg + 1'b1;
                    state_next    = S_FETCH;
                end
                else if (ka_ok)
                begin
                    if (!pend_valid_reg || out_ready)
                    begin
                        out_push        = pend_valid_reg;
                        pend_load       = 1'b1;
                        pend_ka_load    = 1'b1;
                        pend_valid_next = 1'b1;
                        nst_next        = now_reg;
                        state_next      = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FETCH:
            begin
                if (!pend_valid_reg || out_ready)
                begin
                    out_push        = pend_valid_reg;
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    state_next      = S_DECIDE;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_ready)
                begin
                    out_push        = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            fill_reg       <= '0;
            drop_reg       <= '0;
            nst_reg        <= '0;
            started_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            fill_reg       <= fill_next;
            drop_reg       <= drop_next;
            nst_reg        <= nst_next;
            started_reg    <= started_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg    <= MIN_GAP_RST;
            ka_en_reg      <= 1'b0;
            ka_timeout_reg <= KA_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_GAP:    min_gap_reg    <= cfg_data[MIN_GAP_W-1:0];
                CFG_KA_ENABLE:  ka_en_reg      <= cfg_data[0];
                CFG_KA_TIMEOUT: ka_timeout_reg <= cfg_data[KA_TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[write_pos_reg] <= data_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[read_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && (operation == OP_PACE))
        begin
            now_reg <= now_time;
        end
        if (pend_load)
        begin
            pend_byte_reg <= pend_ka_load ? KEEPALIVE_BYTE : rd_data_reg;
            pend_ka_reg   <= pend_ka_load;
        end
    end

    assign res_in.out_byte     = pend_byte_reg;
    assign res_in.is_keepalive = pend_ka_reg;
    assign res_in.last_of_run  = push_last;
    assign res_in.drops_so_far = drop_reg;

    pbrk_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .item      (res_in),
        .can_take  (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (res_out)
    );

    assign out_byte     = res_out.out_byte;
    assign is_keepalive = res_out.is_keepalive;
    assign last_of_run  = res_out.last_of_run;
    assign drops_so_far = res_out.drops_so_far;

endmodule

// ----- rtl/core/pbrk_checker.sv -----
// Port-level checks for the paced byte ring core, bound to the top level.
module pbrk_checker
    import pbrk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        operation,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        out_byte,
    input logic              is_keepalive,
    input logic              last_of_run,
    input logic [DROP_W-1:0] drops_so_far
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(drops_so_far))
        else $error("result transaction changed while stalled");

    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (operation != OP_PACE) |=> !in_stall)
        else $error("non-pace transaction held the input");

    a_ka_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_keepalive |-> out_byte == KEEPALIVE_BYTE)
        else $error("keepalive byte not zero");

    a_ka_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_keepalive |-> last_of_run)
        else $error("keepalive not final of run");

endmodule

bind paced_byte_ring_with_keepalive_core pbrk_checker u_pbrk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .is_keepalive (is_keepalive),
    .last_of_run  (last_of_run),
    .drops_so_far (drops_so_far)
);
